// ===== rtl/dht_pkg.sv =====
// shared types and constants for the dht22 sensor reader
// no dependencies
`default_nettype none

package dht_pkg;

  localparam int FRAME_BITS = 40;
  localparam int ERR_BITS   = 10;
  localparam int TDATA_BITS = 56;

  localparam logic [1:0] CFG_START_LOW = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [1:0] CFG_ONE_THR   = 2'd2;

  localparam logic [11:0] START_LOW_RST = 12'd1100;
  localparam logic [7:0]  TIMEOUT_RST   = 8'd200;
  localparam logic [7:0]  ONE_THR_RST   = 8'd30;

  localparam logic [15:0] HUM_MAX  = 16'd1000;
  localparam logic [14:0] TEMP_MAX = 15'd2000;

  typedef struct packed {
    logic                drive_low;
    logic                busy_res;
    logic                done_res;
    logic [15:0]         humidity_raw;
    logic [15:0]         temperature_raw;
    logic [7:0]          checksum_byte;
    logic [ERR_BITS-1:0] error_flags;
    logic                humidity_ok;
    logic                temperature_ok;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/dht_core.sv =====
// frame sequencer: config registers, phase state and per-word result
// depends on dht_pkg
`default_nettype none

module dht_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [11:0]      cfg_data,
  input  wire logic             en,
  input  wire logic             action,
  input  wire logic             line_in,
  output dht_pkg::result_t      res
);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_START     = 3'd1;
  localparam logic [2:0] PH_RESP_LOW  = 3'd2;
  localparam logic [2:0] PH_RESP_HIGH = 3'd3;
  localparam logic [2:0] PH_RESP_END  = 3'd4;
  localparam logic [2:0] PH_BIT_LOW   = 3'd5;
  localparam logic [2:0] PH_BIT_HIGH  = 3'd6;
  localparam logic [2:0] PH_RELEASE   = 3'd7;

  localparam int FB = dht_pkg::FRAME_BITS;
  localparam int EB = dht_pkg::ERR_BITS;

  logic [11:0]   start_low;
  logic [7:0]    timeout;
  logic [7:0]    one_thr;

  logic [2:0]    phase, phase_next;
  logic [11:0]   tick_count, tick_count_next;
  logic [5:0]    bit_index, bit_index_next;
  logic [FB-1:0] frame, frame_next;
  logic [EB-1:0] error_mask, error_mask_next;
  logic [FB-1:0] result_words, result_words_next;

  logic          drive, done, target;
  logic [3:0]    err_idx;
  logic [1:0]    sec;
  logic [11:0]   tick_inc;
  logic          one_bit;
  logic [5:0]    bit_pos;
  logic [15:0]   hum;
  logic [14:0]   mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_low <= dht_pkg::START_LOW_RST;
      timeout   <= dht_pkg::TIMEOUT_RST;
      one_thr   <= dht_pkg::ONE_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dht_pkg::CFG_START_LOW: start_low <= cfg_data;
        dht_pkg::CFG_TIMEOUT:   timeout   <= cfg_data[7:0];
        dht_pkg::CFG_ONE_THR:   one_thr   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      bit_index    <= '0;
      frame        <= '0;
      error_mask   <= '0;
      result_words <= '0;
    end else if (en) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_index    <= bit_index_next;
      frame        <= frame_next;
      error_mask   <= error_mask_next;
      result_words <= result_words_next;
    end
  end

  always_comb begin
    if (bit_index < 6'd16) begin
      sec = 2'd0;
    end else if (bit_index < 6'd32) begin
      sec = 2'd1;
    end else begin
      sec = 2'd2;
    end
  end

  assign tick_inc = tick_count + 12'd1;
  assign one_bit  = ({1'b0, tick_count} + 13'd1) >= {5'd0, one_thr};
  assign bit_pos  = 6'(FB - 1) - bit_index;

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_index_next    = bit_index;
    frame_next        = frame;
    error_mask_next   = error_mask;
    result_words_next = result_words;
    drive             = 1'b0;
    done              = 1'b0;
    target            = 1'b1;
    err_idx           = 4'd9;

    case (phase)
      PH_RESP_LOW:  begin target = 1'b0; err_idx = 4'd0; end
      PH_RESP_HIGH: begin target = 1'b1; err_idx = 4'd1; end
      PH_RESP_END:  begin target = 1'b0; err_idx = 4'd2; end
      PH_BIT_LOW:   begin target = 1'b1; err_idx = 4'd3 + {1'b0, sec, 1'b0}; end
      PH_BIT_HIGH:  begin target = 1'b0; err_idx = 4'd4 + {1'b0, sec, 1'b0}; end
      default: ;
    endcase

    case (phase)
      PH_IDLE: begin
        if (action) begin
          error_mask_next = '0;
          frame_next      = '0;
          bit_index_next  = '0;
          drive           = 1'b1;
          if (12'd1 >= start_low) begin
            phase_next      = PH_RESP_LOW;
            tick_count_next = '0;
          end else begin
            phase_next      = PH_START;
            tick_count_next = 12'd1;
          end
        end
      end
      PH_START: begin
        drive = 1'b1;
        if (tick_inc >= start_low) begin
          phase_next      = PH_RESP_LOW;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      default: begin
        if (line_in == target) begin
          tick_count_next = '0;
          if (tick_count == '0) begin
            error_mask_next   = error_mask | (EB'(1) << err_idx);
            result_words_next = frame;
            phase_next        = PH_IDLE;
            done              = 1'b1;
          end else if (phase == PH_BIT_HIGH) begin
            frame_next[bit_pos] = one_bit;
            bit_index_next      = bit_index + 6'd1;
            phase_next = (bit_index_next >= 6'(FB)) ? PH_RELEASE : PH_BIT_LOW;
          end else if (phase == PH_RELEASE) begin
            result_words_next = frame;
            phase_next        = PH_IDLE;
            done              = 1'b1;
          end else begin
            phase_next = phase + 3'd1;
          end
        end else if (tick_inc >= {4'd0, timeout}) begin
          error_mask_next   = error_mask | (EB'(1) << err_idx);
          result_words_next = frame;
          phase_next        = PH_IDLE;
          tick_count_next   = '0;
          done              = 1'b1;
        end else begin
          tick_count_next = tick_inc;
        end
      end
    endcase
  end

  assign hum = result_words_next[FB-1 -: 16];
  assign mag = result_words_next[FB-18 -: 15];

  always_comb begin
    res.drive_low       = drive;
    res.busy_res        = (phase_next != PH_IDLE);
    res.done_res        = done;
    res.humidity_raw    = hum;
    res.temperature_raw = result_words_next[FB-17 -: 16];
    res.checksum_byte   = result_words_next[7:0];
    res.error_flags     = error_mask_next;
    res.humidity_ok     = (hum != '0) && (hum <= dht_pkg::HUM_MAX);
    res.temperature_ok  = (mag != '0) && (mag <= dht_pkg::TEMP_MAX);
  end

endmodule

`default_nettype wire

// ===== rtl/dht_obuf.sv =====
// result register with skid stage, takes a word while the last one waits
// depends on dht_pkg
`default_nettype none

module dht_obuf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire dht_pkg::result_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output dht_pkg::result_t      out_data
);

  logic             main_valid;
  logic             skid_valid;
  dht_pkg::result_t main_data;
  dht_pkg::result_t skid_data;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !main_valid) begin
      main_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dht22_sensor_reader.sv =====
// dht22 single-wire sensor reader, one word per microsecond tick
// a result word is registered in the output buffer, in its main stage or, while that one waits, in its skid stage
// throughput: one word per cycle while s_tready is high, set by the phase update in dht_core
// a two-entry output register keeps s_tready high while one result waits
// reset: synchronous, returns to idle, clears the frame and error state
// and loads the register defaults; no clearing pass
`default_nettype none

module dht22_sensor_reader (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,  // line_in, zero fill
  input  wire logic [0:0]                      s_tuser,  // action
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // drive_low, busy_res, done_res, humidity_raw, temperature_raw,
  // checksum_byte, error_flags, humidity_ok, temperature_ok, zero fill
  output logic [dht_pkg::TDATA_BITS-1:0]       m_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [11:0]                     cfg_data
);

  logic             accept;
  dht_pkg::result_t res;
  dht_pkg::result_t out_res;

  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  dht_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .en        (accept),
    .action    (s_tuser[0]),
    .line_in   (s_tdata[0]),
    .res       (res)
  );

  dht_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_ready  (s_tready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {1'b0,
                    out_res.temperature_ok,
                    out_res.humidity_ok,
                    out_res.error_flags,
                    out_res.checksum_byte,
                    out_res.temperature_raw,
                    out_res.humidity_raw,
                    out_res.done_res,
                    out_res.busy_res,
                    out_res.drive_low};

endmodule

`default_nettype wire

// ===== rtl/dht_checker.sv =====
// port-level checks for the dht22 sensor reader, bound to the top level
// depends on dht_pkg
`default_nettype none

module dht_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [dht_pkg::TDATA_BITS-1:0] m_tdata
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // driving the line low only happens with a reading in progress
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1])
    else $error("drive_low without busy");

  // a finished reading leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> !m_tdata[1] && !m_tdata[0])
    else $error("done while busy or driving");

  // humidity flag agrees with the word it reports
  a_hum_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[53] |-> (m_tdata[18:3] != 16'd0) && (m_tdata[18:3] <= 16'd1000))
    else $error("humidity_ok with out-of-range word");

endmodule

bind dht22_sensor_reader dht_checker u_dht_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

// self-checking bench for dht22_sensor_reader: sensor waveforms in, result words out,
// each word predicted by a scoreboard class and compared field by field
// depends on rtl/dht_pkg.sv and rtl/dht22_sensor_reader.sv

module testbench;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_START_LOW = 4'd1,
    ST_RESP_LOW  = 4'd2,
    ST_RESP_HIGH = 4'd3,
    ST_RESP_END  = 4'd4,
    ST_BIT_LOW   = 4'd5,
    ST_BIT_HIGH  = 4'd6,
    ST_RELEASE   = 4'd7
  } reader_state_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // result word layout, drive_low in the lowest bit
  typedef struct packed {
    logic                         temperature_ok;
    logic                         humidity_ok;
    logic [dht_pkg::ERR_BITS-1:0] error_flags;
    logic [7:0]                   checksum_byte;
    logic [15:0]                  temperature_raw;
    logic [15:0]                  humidity_raw;
    logic                         done_res;
    logic                         busy_res;
    logic                         drive_low;
  } tick_result_t;

  class reading_tracker;
    reader_state_t                  state;
    logic [11:0]                    tick_cnt;
    logic [5:0]                     bit_idx;
    logic [dht_pkg::FRAME_BITS-1:0] shift_reg;
    logic [dht_pkg::ERR_BITS-1:0]   err_mask;
    logic [dht_pkg::FRAME_BITS-1:0] frame_words;
    logic [11:0]                    start_low;
    logic [7:0]                     timeout;
    logic [7:0]                     one_thr;
    tick_result_t                   expected_words[$];
    int                             errors;
    int                             ticks_busy;
    int                             readings_done;
    int                             readings_aborted;
    logic [dht_pkg::ERR_BITS-1:0]   errors_seen;

    function new();
      state = ST_IDLE;
      tick_cnt = '0;
      bit_idx = '0;
      shift_reg = '0;
      err_mask = '0;
      frame_words = '0;
      start_low = dht_pkg::START_LOW_RST;
      timeout = dht_pkg::TIMEOUT_RST;
      one_thr = dht_pkg::ONE_THR_RST;
      errors = 0;
      ticks_busy = 0;
      readings_done = 0;
      readings_aborted = 0;
      errors_seen = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [11:0] data);
      case (idx)
        dht_pkg::CFG_START_LOW: start_low = data;
        dht_pkg::CFG_TIMEOUT:   timeout = data[7:0];
        dht_pkg::CFG_ONE_THR:   one_thr = data[7:0];
        default: ;
      endcase
    endfunction

    // bits taken so far keep their frame positions, the rest read as zero
    function void abort_frame(logic [dht_pkg::ERR_BITS-1:0] flag);
      int sh;
      sh = (bit_idx >= dht_pkg::FRAME_BITS) ? 0 : dht_pkg::FRAME_BITS - int'(bit_idx);
      err_mask |= flag;
      errors_seen |= flag;
      frame_words = shift_reg << sh;
      state = ST_IDLE;
      tick_cnt = '0;
      readings_aborted++;
    endfunction

    function void note_tick(logic act, logic line);
      tick_result_t                 r;
      logic                         target;
      logic                         drive;
      logic                         done;
      logic [dht_pkg::ERR_BITS-1:0] flag;
      int                           sec;
      logic [15:0]                  hum;
      logic [15:0]                  tmp;
      if (state != ST_IDLE || act) ticks_busy++;
      drive = 1'b0;
      done = 1'b0;
      case (state)
        ST_IDLE: if (act) begin
          err_mask = '0;
          shift_reg = '0;
          bit_idx = '0;
          drive = 1'b1;
          tick_cnt = 12'd1;
          state = ST_START_LOW;
          if (tick_cnt >= start_low) begin
            state = ST_RESP_LOW;
            tick_cnt = '0;
          end
        end
        ST_START_LOW: begin
          drive = 1'b1;
          tick_cnt++;
          if (tick_cnt >= start_low) begin
            state = ST_RESP_LOW;
            tick_cnt = '0;
          end
        end
        default: begin
          sec = (bit_idx < 16) ? 0 : (bit_idx < 32) ? 1 : 2;
          case (state)
            ST_RESP_LOW: begin
              target = 1'b0;
              flag = 10'd1;
            end
            ST_RESP_HIGH: begin
              target = 1'b1;
              flag = 10'd1 << 1;
            end
            ST_RESP_END: begin
              target = 1'b0;
              flag = 10'd1 << 2;
            end
            ST_BIT_LOW: begin
              target = 1'b1;
              flag = 10'd1 << (3 + 2 * sec);
            end
            ST_BIT_HIGH: begin
              target = 1'b0;
              flag = 10'd1 << (4 + 2 * sec);
            end
            default: begin
              target = 1'b1;
              flag = 10'd1 << 9;
            end
          endcase
          if (line == target) begin
            if (tick_cnt == 0) begin
              abort_frame(flag);
              done = 1'b1;
            end else if (state == ST_BIT_HIGH) begin
              // high length counts the rising tick too
              shift_reg = {shift_reg[dht_pkg::FRAME_BITS-2:0],
                           (int'(tick_cnt) + 1 >= int'(one_thr))};
              bit_idx++;
              state = (bit_idx >= dht_pkg::FRAME_BITS) ? ST_RELEASE : ST_BIT_LOW;
              tick_cnt = '0;
            end else if (state == ST_RELEASE) begin
              frame_words = shift_reg;
              state = ST_IDLE;
              tick_cnt = '0;
              done = 1'b1;
              readings_done++;
            end else begin
              state = reader_state_t'(state + 4'd1);
              tick_cnt = '0;
            end
          end else begin
            tick_cnt++;
            if (tick_cnt >= timeout) begin
              abort_frame(flag);
              done = 1'b1;
            end
          end
        end
      endcase
      hum = frame_words[39:24];
      tmp = frame_words[23:8];
      r.drive_low = drive;
      r.busy_res = (state != ST_IDLE);
      r.done_res = done;
      r.humidity_raw = hum;
      r.temperature_raw = tmp;
      r.checksum_byte = frame_words[7:0];
      r.error_flags = err_mask;
      r.humidity_ok = (hum >= 1 && hum <= dht_pkg::HUM_MAX);
      r.temperature_ok = (tmp[14:0] >= 1 && tmp[14:0] <= dht_pkg::TEMP_MAX);
      expected_words.push_back(r);
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [dht_pkg::TDATA_BITS-1:0] w);
      tick_result_t got;
      tick_result_t want;
      got = w[54:0];
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare("drive_low", want.drive_low, got.drive_low);
      compare("busy_res", want.busy_res, got.busy_res);
      compare("done_res", want.done_res, got.done_res);
      compare("humidity_raw", want.humidity_raw, got.humidity_raw);
      compare("temperature_raw", want.temperature_raw, got.temperature_raw);
      compare("checksum_byte", want.checksum_byte, got.checksum_byte);
      compare("error_flags", want.error_flags, got.error_flags);
      compare("humidity_ok", want.humidity_ok, got.humidity_ok);
      compare("temperature_ok", want.temperature_ok, got.temperature_ok);
      compare("zero fill", 0, w[dht_pkg::TDATA_BITS-1]);
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [7:0]                     s_tdata;   // line_in, zero fill
  logic [0:0]                     s_tuser;   // action
  logic                           m_tvalid;
  logic                           m_tready;
  // drive_low, busy_res, done_res, humidity_raw, temperature_raw,
  // checksum_byte, error_flags, humidity_ok, temperature_ok, zero fill
  logic [dht_pkg::TDATA_BITS-1:0] m_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [1:0]                     cfg_index;
  logic [11:0]                    cfg_data;

  reading_tracker sb;
  idle_mode_t     idle_mode;
  int             hold_countdown;
  int             bad_odds;
  int             reading_no;
  int             settings_used;

  dht22_sensor_reader i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_pct(logic receiver_side);
    case (idle_mode)
      IDLE_SENDER:   return receiver_side ? 0 : 88;
      IDLE_RECEIVER: return receiver_side ? 88 : 0;
      IDLE_BOTH:     return 12;
      default:       return 0;
    endcase
  endfunction

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_tick(input logic act, input logic line);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, line};
    s_tuser <= act;
    do @(posedge clk); while (!s_tready);
    sb.note_tick(act, line);
    if (hold_countdown > 0) begin
      hold_countdown--;
      if (hold_countdown == 0) drain();
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input int start, input int tmo, input int thr);
    drain();
    write_reg(dht_pkg::CFG_START_LOW, 12'(start));
    write_reg(dht_pkg::CFG_TIMEOUT, 12'(tmo));
    write_reg(dht_pkg::CFG_ONE_THR, 12'(thr));
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // run length within the timeout, now and then a broken one
  function automatic int pick_len(int lo, int hi);
    int t;
    t = sb.timeout;
    if (bad_odds > 0 && $urandom_range(1, bad_odds) == 1)
      return $urandom_range(0, 1) ? 1 : t + 2;
    if (hi > t) hi = t;
    if (hi < 0) hi = 0;
    if (lo > hi) lo = hi;
    return $urandom_range(lo, hi);
  endfunction

  task automatic level_run(input logic line, input int len);
    for (int i = 0; i < len; i++) begin
      send_tick($urandom_range(0, 15) == 0, line);
      if (sb.state == ST_IDLE) return;
    end
  endtask

  function automatic logic [dht_pkg::FRAME_BITS-1:0] make_frame();
    logic [15:0] hum;
    logic [15:0] tmp;
    case ($urandom_range(0, 4))
      0: hum = 16'd0;
      1: hum = 16'($urandom_range(1, 1000));
      2: hum = 16'($urandom_range(1000, 1001));
      3: hum = 16'd1;
      default: hum = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: tmp = 16'd0;
      1: tmp = 16'($urandom_range(1, 2000));
      2: tmp = 16'($urandom_range(2000, 2001));
      3: tmp = 16'd1;
      default: tmp = 16'($urandom);
    endcase
    tmp[15] = 1'($urandom_range(0, 1));
    return {hum, tmp, 8'($urandom)};
  endfunction

  // start request, response and 40 bits, stopping once the block gives up
  task automatic read_frame(input logic [dht_pkg::FRAME_BITS-1:0] frame);
    int r;
    int lo;
    int hi;
    while (sb.state != ST_IDLE) send_tick(1'b0, 1'b1);
    idle_mode = idle_mode_t'(reading_no % 4);
    reading_no++;
    r = sb.one_thr;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    while (sb.state == ST_START_LOW)
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    level_run(1'b1, pick_len(1, (sb.timeout > 3) ? 3 : int'(sb.timeout) - 1));
    if (sb.state == ST_IDLE) return;
    level_run(1'b0, pick_len(2, 3));
    if (sb.state == ST_IDLE) return;
    level_run(1'b1, pick_len(2, 3));
    if (sb.state == ST_IDLE) return;
    for (int i = dht_pkg::FRAME_BITS - 1; i >= 0; i--) begin
      level_run(1'b0, pick_len(2, 3));
      if (sb.state == ST_IDLE) return;
      if (frame[i] || r <= 2) begin
        lo = (r > 2) ? r : 2;
        hi = lo + 2;
      end else if (r <= 16 || $urandom_range(0, 39) == 0) begin
        hi = r - 1;
        lo = (hi > 3) ? hi - 2 : 2;
      end else begin
        lo = 2;
        hi = 3;
      end
      level_run(1'b1, pick_len(lo, hi));
      if (sb.state == ST_IDLE) return;
    end
    level_run(1'b0, pick_len(2, 3));
    if (sb.state == ST_IDLE) return;
    level_run(1'b1, 1);
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  initial begin
    #4_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sb = new();
    idle_mode = IDLE_NONE;
    hold_countdown = 0;
    bad_odds = 0;
    reading_no = 0;
    settings_used = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // plain ticks under the reset settings
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);

    configure(1, 3, 2);
    // missing falling response edge, start request while busy
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    // response low never comes
    send_tick(1'b1, 1'b1);
    repeat (3) send_tick(1'b0, 1'b1);
    // missing rising response edge
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    // missing falling edge that ends the response
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // zero start length and zero timeout
    configure(0, 0, 1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);

    while (sb.ticks_busy < 350) begin
      if (reading_no % 2 == 0)
        configure($urandom_range(1, 8), $urandom_range(6, 20), $urandom_range(2, 8));
      bad_odds = ($urandom_range(0, 2) == 0) ? 40 : 0;
      if (reading_no == 0 || $urandom_range(0, 5) == 0) hold_countdown = $urandom_range(20, 200);
      if (reading_no > 0 && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(10, 40))
          send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
      end
      read_frame(make_frame());
    end

    bad_odds = 0;
    configure(1, 255, 255);
    read_frame(40'd1 << $urandom_range(0, dht_pkg::FRAME_BITS - 1));
    configure(300, 6, 1);
    read_frame(make_frame());
    configure(3, 1, 2);
    repeat (6) read_frame(make_frame());
    configure(0, 0, 0);
    repeat (6) read_frame(make_frame());

    drain();
    repeat (10) @(posedge clk);
    $display("%0d busy ticks over %0d readings and %0d register settings, four idle patterns",
             sb.ticks_busy, reading_no, settings_used);
    $display("%0d frames complete, %0d aborted, error bits hit 0x%03h",
             sb.readings_done, sb.readings_aborted, sb.errors_seen);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
